@@ rtl/hall_wheel_speed_meter_core_defines.svh @@
// assertion macros of the wheel speed meter rtl, used by the sequencer
`ifndef HALL_WHEEL_SPEED_METER_CORE_DEFINES_SVH
`define HALL_WHEEL_SPEED_METER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define HWSM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hwsm assertion failed");

// next-cycle implication
`define HWSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hwsm assertion failed");

`else

`define HWSM_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define HWSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/hwsm_pkg.sv @@
// types and constants of the wheel speed meter
package hwsm_pkg;

  localparam int unsigned THR_W    = 15;
  localparam int unsigned DIST_W   = 24;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned PULSE_W  = 20;
  localparam int unsigned SPEED_W  = 16;
  localparam int unsigned DUTY_W   = 15;
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;

  // shared divider: numerator covers high*25600 and distance*1000
  localparam int unsigned DIV_NUM_W = 35;
  localparam int unsigned DIV_DEN_W = 32;

  localparam logic [DUTY_W-1:0]  DUTY_FULL_SCALE = 15'd25600;
  localparam logic [SPEED_W-1:0] SPEED_MAX       = 16'hFFFF;
  localparam logic [9:0]         UM_US_TO_MM_S   = 10'd1000;

  localparam logic [THR_W-1:0]  RST_UPPER_THR  = 15'd12800;
  localparam logic [DIST_W-1:0] RST_DISTANCE   = '0;
  localparam logic [TIME_W-1:0] RST_TIMEOUT    = 32'd1000000;
  localparam logic [TIME_W-1:0] RST_INIT_TIME  = '0;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_UPPER_THR = 2'd0;
  localparam logic [1:0] REG_DISTANCE  = 2'd1;
  localparam logic [1:0] REG_TIMEOUT   = 2'd2;
  localparam logic [1:0] REG_INIT_TIME = 2'd3;

  typedef struct packed {
    logic [THR_W-1:0]  upper_threshold;
    logic [DIST_W-1:0] distance_per_pulse_um;
    logic [TIME_W-1:0] timeout_us;
    logic [TIME_W-1:0] init_time_us;
  } cfg_t;

  typedef struct packed {
    logic cap;         // capture input beat
    logic duty_start;  // start duty division
    logic duty_zero;   // load zero duty
    logic duty_ld;     // load duty quotient
    logic eval;        // threshold test and speed candidate
    logic spd_start;   // start speed division
    logic spd_ld;      // load saturated speed quotient
    logic commit;      // update state and result beat
  } ctrl_cmd_t;

  typedef struct packed {
    logic width_zero;
    logic edge_hit;
    logic dt_zero;
    logic div_busy;
    logic div_done;
  } ctrl_sts_t;

endpackage

@@ rtl/hwsm_div.sv @@
// restoring divider, one quotient bit per cycle
module hwsm_div #(
  parameter int unsigned NUM_W = hwsm_pkg::DIV_NUM_W,
  parameter int unsigned DEN_W = hwsm_pkg::DIV_DEN_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             qbit;

  assign trial = {rem_q, num_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign qbit  = (trial >= {1'b0, den_q});

  always_comb begin
    rem_d = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    num_d = {num_q[NUM_W-2:0], qbit};
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

@@ rtl/hwsm_ctrl.sv @@
// sequencer for one item: duty division (skipped for a zero width), threshold test, speed division on an event, commit
`include "hall_wheel_speed_meter_core_defines.svh"

module hwsm_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  hwsm_pkg::ctrl_sts_t   sts_i,
  output hwsm_pkg::ctrl_cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DUTY,
    S_DUTY_WAIT,
    S_EVAL,
    S_SPEED_WAIT,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_acc;
  logic   slot_free;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign slot_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_o.cap = 1'b1;
          state_d   = S_DUTY;
        end
      end
      S_DUTY: begin
        if (sts_i.width_zero) begin
          cmd_o.duty_zero = 1'b1;
          state_d         = S_EVAL;
        end else begin
          cmd_o.duty_start = 1'b1;
          state_d          = S_DUTY_WAIT;
        end
      end
      S_DUTY_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.duty_ld = 1'b1;
          state_d       = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        // a zero interval saturates without dividing
        if (sts_i.edge_hit && !sts_i.dt_zero) begin
          cmd_o.spd_start = 1'b1;
          state_d         = S_SPEED_WAIT;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_SPEED_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.spd_ld = 1'b1;
          state_d      = S_FINISH;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `HWSM_ASSERT_NXT(a_accept_starts_duty, clk_i, rst_ni, in_acc, state_q == S_DUTY)
  `HWSM_ASSERT_NOW(a_div_start_free, clk_i, rst_ni,
                   cmd_o.duty_start || cmd_o.spd_start, !sts_i.div_busy)
  `HWSM_ASSERT_NOW(a_wait_has_div, clk_i, rst_ni,
                   state_q == S_DUTY_WAIT || state_q == S_SPEED_WAIT,
                   sts_i.div_busy || sts_i.div_done)
  `HWSM_ASSERT_NXT(a_commit_shows_beat, clk_i, rst_ni, cmd_o.commit, out_valid_q)

endmodule

@@ rtl/hwsm_dpath.sv @@
// operand registers, item state and the shared divider
module hwsm_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hwsm_pkg::cfg_t                cfg_i,
  input  logic [hwsm_pkg::PULSE_W-1:0]  pulse_high_us_i,
  input  logic [hwsm_pkg::PULSE_W-1:0]  pulse_low_us_i,
  input  logic [hwsm_pkg::TIME_W-1:0]   timestamp_us_i,
  input  hwsm_pkg::ctrl_cmd_t           cmd_i,
  output hwsm_pkg::ctrl_sts_t           sts_o,
  output logic [hwsm_pkg::SPEED_W-1:0]  speed_mm_s_o,
  output logic [hwsm_pkg::DUTY_W-1:0]   duty_cycle_o,
  output logic                          edge_seen_o
);

  localparam int unsigned NW = hwsm_pkg::DIV_NUM_W;
  localparam int unsigned DW = hwsm_pkg::DIV_DEN_W;

  logic [hwsm_pkg::PULSE_W-1:0] high_q, low_q;
  logic [hwsm_pkg::TIME_W-1:0]  ts_q;
  logic [hwsm_pkg::DUTY_W-1:0]  duty_q;
  logic                         edge_q, above_q;
  logic [hwsm_pkg::SPEED_W-1:0] cand_q;

  // item state, also the result beat
  logic                         prev_above_q;
  logic [hwsm_pkg::DUTY_W-1:0]  last_duty_q;
  logic [hwsm_pkg::TIME_W-1:0]  last_edge_q;
  logic [hwsm_pkg::SPEED_W-1:0] held_q;
  logic                         edge_out_q;

  logic [hwsm_pkg::PULSE_W:0]   wsum;
  logic [NW-1:0]                duty_num, spd_num, div_num, quot;
  logic [DW-1:0]                div_den;
  logic                         div_busy, div_done;
  logic [hwsm_pkg::DUTY_W:0]    dsum;
  logic [hwsm_pkg::DUTY_W-1:0]  avg;
  logic                         above, edge_hit;
  logic [hwsm_pkg::TIME_W-1:0]  dt, elapsed;
  logic [hwsm_pkg::SPEED_W-1:0] spd_sat;
  logic                         force_zero;

  assign wsum     = (hwsm_pkg::PULSE_W+1)'(high_q) + (hwsm_pkg::PULSE_W+1)'(low_q);
  assign duty_num = NW'(high_q) * NW'(hwsm_pkg::DUTY_FULL_SCALE);
  assign spd_num  = NW'(cfg_i.distance_per_pulse_um) * NW'(hwsm_pkg::UM_US_TO_MM_S);
  assign dt       = ts_q - last_edge_q;

  assign div_num = cmd_i.spd_start ? spd_num : duty_num;
  assign div_den = cmd_i.spd_start ? dt : DW'(wsum);

  hwsm_div #(
    .NUM_W (NW),
    .DEN_W (DW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.duty_start || cmd_i.spd_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign dsum     = (hwsm_pkg::DUTY_W+1)'(duty_q) + (hwsm_pkg::DUTY_W+1)'(last_duty_q);
  assign avg      = dsum[hwsm_pkg::DUTY_W:1];
  assign above    = (avg >= cfg_i.upper_threshold);
  assign edge_hit = above && !prev_above_q;

  assign spd_sat = (quot[NW-1:hwsm_pkg::SPEED_W] != '0) ? hwsm_pkg::SPEED_MAX
                                                       : quot[hwsm_pkg::SPEED_W-1:0];

  // an event in this item restarts the elapsed time at zero
  assign elapsed    = edge_q ? '0 : dt;
  assign force_zero = (elapsed >= cfg_i.timeout_us) || (ts_q <= cfg_i.init_time_us);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      high_q <= pulse_high_us_i;
      low_q  <= pulse_low_us_i;
      ts_q   <= timestamp_us_i;
    end
    if (cmd_i.duty_zero) begin
      duty_q <= '0;
    end else if (cmd_i.duty_ld) begin
      duty_q <= quot[hwsm_pkg::DUTY_W-1:0];
    end
    if (cmd_i.eval) begin
      edge_q  <= edge_hit;
      above_q <= above;
      cand_q  <= edge_hit ? hwsm_pkg::SPEED_MAX : held_q;
    end else if (cmd_i.spd_ld) begin
      cand_q <= spd_sat;
    end
    if (cmd_i.commit) begin
      edge_out_q <= edge_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_above_q <= 1'b0;
      last_duty_q  <= '0;
      last_edge_q  <= '0;
      held_q       <= '0;
    end else if (cmd_i.commit) begin
      prev_above_q <= above_q;
      last_duty_q  <= duty_q;
      if (edge_q) begin
        last_edge_q <= ts_q;
      end
      held_q <= force_zero ? '0 : cand_q;
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.width_zero = (high_q == '0) || (low_q == '0);
    sts_o.edge_hit   = edge_hit;
    sts_o.dt_zero    = (dt == '0);
    sts_o.div_busy   = div_busy;
    sts_o.div_done   = div_done;
  end

  assign speed_mm_s_o = held_q;
  assign duty_cycle_o = last_duty_q;
  assign edge_seen_o  = edge_out_q;

endmodule

@@ rtl/hall_wheel_speed_meter_core.sv @@
// Wheel speed from a Hall sensor's PWM duty cycle. Each input beat (high and
// low pulse width, timestamp) gives one result beat (speed in mm/s, duty
// cycle in percent*256, event flag). The duty division is skipped when a pulse
// width is zero and the speed division runs only on a magnet event: one
// 35-step restoring divider, one quotient bit per cycle, is used
// first for the duty cycle and then for the speed. A new beat is taken once
// the previous item has moved into the output register, so the next item
// runs while a result beat is still stalled. Registers sit on an APB port at
// byte addresses 0x0 (upper threshold), 0x4 (distance per pulse in um),
// 0x8 (timeout in us) and 0xC (init time in us).
module hall_wheel_speed_meter_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hwsm_pkg::ADDR_W-1:0]   paddr,
  input  logic [hwsm_pkg::DATA_W-1:0]   pwdata,
  output logic [hwsm_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [hwsm_pkg::PULSE_W-1:0]  pulse_high_us_i,
  input  logic [hwsm_pkg::PULSE_W-1:0]  pulse_low_us_i,
  input  logic [hwsm_pkg::TIME_W-1:0]   timestamp_us_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [hwsm_pkg::SPEED_W-1:0]  speed_mm_s_o,
  output logic [hwsm_pkg::DUTY_W-1:0]   duty_cycle_o,
  output logic                          edge_seen_o
);

  hwsm_pkg::cfg_t      cfg_q;
  hwsm_pkg::ctrl_cmd_t cmd;
  hwsm_pkg::ctrl_sts_t sts;
  logic                wr_en;
  logic [1:0]          reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.upper_threshold       <= hwsm_pkg::RST_UPPER_THR;
      cfg_q.distance_per_pulse_um <= hwsm_pkg::RST_DISTANCE;
      cfg_q.timeout_us            <= hwsm_pkg::RST_TIMEOUT;
      cfg_q.init_time_us          <= hwsm_pkg::RST_INIT_TIME;
    end else if (wr_en) begin
      case (reg_idx)
        hwsm_pkg::REG_UPPER_THR: begin
          cfg_q.upper_threshold <= pwdata[hwsm_pkg::THR_W-1:0];
        end
        hwsm_pkg::REG_DISTANCE: begin
          cfg_q.distance_per_pulse_um <= pwdata[hwsm_pkg::DIST_W-1:0];
        end
        hwsm_pkg::REG_TIMEOUT: begin
          cfg_q.timeout_us <= pwdata[hwsm_pkg::TIME_W-1:0];
        end
        hwsm_pkg::REG_INIT_TIME: begin
          cfg_q.init_time_us <= pwdata[hwsm_pkg::TIME_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      hwsm_pkg::REG_UPPER_THR: prdata = hwsm_pkg::DATA_W'(cfg_q.upper_threshold);
      hwsm_pkg::REG_DISTANCE:  prdata = hwsm_pkg::DATA_W'(cfg_q.distance_per_pulse_um);
      hwsm_pkg::REG_TIMEOUT:   prdata = hwsm_pkg::DATA_W'(cfg_q.timeout_us);
      hwsm_pkg::REG_INIT_TIME: prdata = hwsm_pkg::DATA_W'(cfg_q.init_time_us);
      default:                 prdata = '0;
    endcase
  end

  hwsm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hwsm_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .pulse_high_us_i (pulse_high_us_i),
    .pulse_low_us_i  (pulse_low_us_i),
    .timestamp_us_i  (timestamp_us_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .speed_mm_s_o    (speed_mm_s_o),
    .duty_cycle_o    (duty_cycle_o),
    .edge_seen_o     (edge_seen_o)
  );

endmodule

@@ tb/tb_hall_wheel_speed_meter_core.sv @@
// self-checking testbench of the hall sensor wheel speed meter core
`timescale 1ns / 1ps

module tb_hall_wheel_speed_meter_core;

  localparam int unsigned PULSE_W = hwsm_pkg::PULSE_W;
  localparam int unsigned TIME_W  = hwsm_pkg::TIME_W;
  localparam int unsigned SPEED_W = hwsm_pkg::SPEED_W;
  localparam int unsigned DUTY_W  = hwsm_pkg::DUTY_W;
  localparam int unsigned THR_W   = hwsm_pkg::THR_W;
  localparam int unsigned DIST_W  = hwsm_pkg::DIST_W;
  localparam int unsigned ADDR_W  = hwsm_pkg::ADDR_W;
  localparam int unsigned DATA_W  = hwsm_pkg::DATA_W;

  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned STUCK_LIMIT = 4000;
  localparam int unsigned SETTLE_CYC  = 100;
  localparam int unsigned DRAIN_CYC   = 200;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 240;

  typedef struct packed {
    logic [PULSE_W-1:0] high;
    logic [PULSE_W-1:0] low;
    logic [TIME_W-1:0]  ts;
  } pulse_beat_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [DUTY_W-1:0]  duty;
    logic               seen;
  } reading_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [PULSE_W-1:0] pulse_high_us_i = '0;
  logic [PULSE_W-1:0] pulse_low_us_i = '0;
  logic [TIME_W-1:0] timestamp_us_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [SPEED_W-1:0] speed_mm_s_o;
  logic [DUTY_W-1:0] duty_cycle_o;
  logic edge_seen_o;

  hall_wheel_speed_meter_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .pulse_high_us_i (pulse_high_us_i),
    .pulse_low_us_i  (pulse_low_us_i),
    .timestamp_us_i  (timestamp_us_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .speed_mm_s_o    (speed_mm_s_o),
    .duty_cycle_o    (duty_cycle_o),
    .edge_seen_o     (edge_seen_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // register copies
  logic [THR_W-1:0]  thr_q;
  logic [DIST_W-1:0] dist_q;
  logic [TIME_W-1:0] tmo_q;
  logic [TIME_W-1:0] init_q;

  // meter state
  logic               was_above;
  logic [DUTY_W-1:0]  prior_duty;
  logic [TIME_W-1:0]  event_ts;
  logic [SPEED_W-1:0] speed_hold;

  pulse_beat_t pulse_q[$];
  reading_t    reading_q[$];
  pulse_beat_t cur_beat = '0;

  int unsigned send_gap_max = 5;
  int unsigned recv_hold_max = 5;
  int unsigned send_wait = 0;
  int unsigned hold_left = 0;
  int unsigned result_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned stuck_cyc = 0;
  logic [TIME_W-1:0] clock_us;

  function automatic reading_t wheel_step(pulse_beat_t b);
    reading_t r;
    logic [63:0] quo;
    logic [TIME_W-1:0] dt;
    logic [15:0] avg;
    logic [DUTY_W-1:0] duty;
    logic above;
    logic hit;
    if (b.high == 0 || b.low == 0) begin
      duty = '0;
    end else begin
      quo = (64'(b.high) * 64'(hwsm_pkg::DUTY_FULL_SCALE)) / (64'(b.high) + 64'(b.low));
      duty = quo[DUTY_W-1:0];
    end
    avg = (16'(duty) + 16'(prior_duty)) >> 1;
    above = (avg >= 16'(thr_q));
    hit = above && !was_above;
    if (hit) begin
      dt = b.ts - event_ts;
      if (dt == 0) begin
        speed_hold = hwsm_pkg::SPEED_MAX;
      end else begin
        quo = (64'(dist_q) * 64'(hwsm_pkg::UM_US_TO_MM_S)) / 64'(dt);
        speed_hold = (quo > 64'(hwsm_pkg::SPEED_MAX)) ? hwsm_pkg::SPEED_MAX
                                                      : quo[SPEED_W-1:0];
      end
      event_ts = b.ts;
    end
    dt = b.ts - event_ts;
    if (dt >= tmo_q || b.ts <= init_q) speed_hold = '0;
    was_above = above;
    prior_duty = duty;
    r.speed = speed_hold;
    r.duty = duty;
    r.seen = hit;
    return r;
  endfunction

  // sender: one beat per draw of the gap
  always @(posedge clk_i) begin : drive_pulses
    logic v;
    v = in_valid_i;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        reading_q.push_back(wheel_step(cur_beat));
        send_wait = $urandom_range(0, send_gap_max);
        v = 1'b0;
      end
      if (!v) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (pulse_q.size() > 0) begin
          cur_beat = pulse_q.pop_front();
          v = 1'b1;
        end
      end
    end
    in_valid_i <= v;
    pulse_high_us_i <= cur_beat.high;
    pulse_low_us_i <= cur_beat.low;
    timestamp_us_i <= cur_beat.ts;
  end

  // receiver: check each result beat, then stall for a drawn count
  always @(posedge clk_i) begin : watch_readings
    reading_t want;
    int unsigned h;
    h = hold_left;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        result_cnt++;
        if (reading_q.size() == 0) begin
          err_cnt++;
          $display("%0t: result beat with none expected, got speed %0d duty %0d edge %0d",
                   $time, speed_mm_s_o, duty_cycle_o, edge_seen_o);
        end else begin
          want = reading_q.pop_front();
          if (speed_mm_s_o !== want.speed) begin
            err_cnt++;
            $display("%0t: speed_mm_s expected %0d got %0d", $time, want.speed,
                     speed_mm_s_o);
          end
          if (duty_cycle_o !== want.duty) begin
            err_cnt++;
            $display("%0t: duty_cycle expected %0d got %0d", $time, want.duty,
                     duty_cycle_o);
          end
          if (edge_seen_o !== want.seen) begin
            err_cnt++;
            $display("%0t: edge_seen expected %0d got %0d", $time, want.seen,
                     edge_seen_o);
          end
        end
        // long hold-offs let the core back up into its input
        if (result_cnt == 150 || result_cnt == 1100) h = LONG_HOLD;
        else h = $urandom_range(0, recv_hold_max);
      end else if (h > 0) begin
        h--;
      end
    end
    hold_left = h;
    out_stall_i <= (h != 0);
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable))
        stuck_cyc = 0;
      else
        stuck_cyc++;
      if (stuck_cyc >= STUCK_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [DATA_W-1:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      hwsm_pkg::REG_UPPER_THR: thr_q = val[THR_W-1:0];
      hwsm_pkg::REG_DISTANCE:  dist_q = val[DIST_W-1:0];
      hwsm_pkg::REG_TIMEOUT:   tmo_q = val[TIME_W-1:0];
      hwsm_pkg::REG_INIT_TIME: init_q = val[TIME_W-1:0];
      default: ;
    endcase
  endtask

  task automatic push_pulse(logic [PULSE_W-1:0] h, logic [PULSE_W-1:0] l,
                            logic [TIME_W-1:0] t);
    pulse_beat_t b;
    b.high = h;
    b.low = l;
    b.ts = t;
    pulse_q.push_back(b);
  endtask

  task automatic wait_settled();
    while (pulse_q.size() != 0 || in_valid_i || reading_q.size() != 0) @(posedge clk_i);
  endtask

  // random width with a random bit length, never zero
  function automatic logic [PULSE_W-1:0] rand_width();
    logic [PULSE_W-1:0] w;
    w = PULSE_W'($urandom);
    w = w & PULSE_W'((1 << $urandom_range(1, PULSE_W)) - 1);
    return (w == '0) ? PULSE_W'(1) : w;
  endfunction

  // magnet passes: runs of high and low duty with a rising clock, plus noise
  task automatic fill_phase(int unsigned n, int unsigned step_max);
    logic [PULSE_W-1:0] h;
    logic [PULSE_W-1:0] l;
    logic [TIME_W-1:0] t;
    int unsigned run;
    bit present;
    run = 0;
    present = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 12) begin
        h = ($urandom_range(0, 4) == 0) ? '0 : PULSE_W'($urandom);
        l = ($urandom_range(0, 4) == 0) ? '0 : PULSE_W'($urandom);
        t = ($urandom_range(0, 1) == 0) ? $urandom : clock_us;
      end else begin
        if (run == 0) begin
          present = !present;
          run = $urandom_range(1, 4);
        end
        run--;
        if (present) begin
          h = rand_width();
          l = PULSE_W'(1 + ($urandom % (h / 3 + 1)));
        end else begin
          l = rand_width();
          h = PULSE_W'(1 + ($urandom % (l / 3 + 1)));
        end
        if ($urandom_range(0, 9) != 0) clock_us += $urandom_range(1, step_max);
        t = clock_us;
      end
      push_pulse(h, l, t);
    end
  endtask

  initial begin : stimulus
    int unsigned step_max;
    logic [THR_W-1:0] thr;
    logic [DIST_W-1:0] dist_um;
    logic [TIME_W-1:0] tmo;
    logic [TIME_W-1:0] init;
    thr_q = hwsm_pkg::RST_UPPER_THR;
    dist_q = hwsm_pkg::RST_DISTANCE;
    tmo_q = hwsm_pkg::RST_TIMEOUT;
    init_q = hwsm_pkg::RST_INIT_TIME;
    was_above = 1'b0;
    prior_duty = '0;
    event_ts = '0;
    speed_hold = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    cfg_write(hwsm_pkg::REG_DISTANCE, 32'd100000);
    push_pulse(20'h0, 20'h1, 32'd0);
    push_pulse(20'h1, 20'h0, 32'd5);
    push_pulse(20'hFFFFF, 20'hFFFFF, 32'd10);
    push_pulse(20'hFFFFF, 20'h1, 32'd20);         // crossing right after reset, saturates
    push_pulse(20'h1, 20'hFFFFF, 32'd30);
    push_pulse(20'h1, 20'hFFFFF, 32'd40);
    push_pulse(20'hFFFFF, 20'h1, 32'd5000);
    push_pulse(20'hFFFFF, 20'h1, 32'd6020);       // normal crossing
    push_pulse(20'h1, 20'hFFFFF, 32'd7000);
    push_pulse(20'h1, 20'hFFFFF, 32'd7000);
    push_pulse(20'hFFFFF, 20'h1, 32'd6020);
    push_pulse(20'hFFFFF, 20'h1, 32'd6020);       // zero time since last crossing
    push_pulse(20'hFFFFF, 20'h1, 32'd1006020);    // timed out
    push_pulse(20'h0, 20'h0, 32'hFFFFFFF0);
    push_pulse(20'h1, 20'hFFFFF, 32'hFFFFFFF0);
    push_pulse(20'hFFFFF, 20'h1, 32'hFFFFFFF8);
    push_pulse(20'hFFFFF, 20'h1, 32'h00000010);   // timestamp wraps
    push_pulse(20'h80000, 20'h80000, 32'h00000020);
    push_pulse(20'hABCDE, 20'h54321, 32'h5555AAAA);
    push_pulse(20'h7FFFF, 20'h00001, 32'hAAAA5555);

    for (int unsigned k = 0; k < PHASES; k++) begin
      wait_settled();
      repeat (SETTLE_CYC) @(posedge clk_i);
      clock_us = $urandom;
      step_max = $urandom_range(10, 100000);
      thr = (k == 1) ? 15'd0 : (k == 2) ? 15'd25600 : (k == 3) ? 15'h7FFF :
            15'($urandom_range(2000, 24000));
      dist_um = (k == 4) ? 24'hFFFFFF : (k == 5) ? 24'd0 :
                24'($urandom_range(1, 1 << $urandom_range(4, 23)));
      tmo = (k == 6) ? 32'd0 : (k == 7) ? 32'hFFFFFFFF : $urandom_range(1000, 3000000);
      init = (k == 0) ? clock_us + step_max * 40 : (k == 5) ? 32'hFFFFFFFF :
             (k % 2 == 1) ? $urandom : 32'd0;
      cfg_write(hwsm_pkg::REG_UPPER_THR, 32'(thr));
      cfg_write(hwsm_pkg::REG_DISTANCE, 32'(dist_um));
      cfg_write(hwsm_pkg::REG_TIMEOUT, tmo);
      cfg_write(hwsm_pkg::REG_INIT_TIME, init);
      send_gap_max = (k % 3 == 2) ? 0 : 5;
      recv_hold_max = (k % 3 == 1) ? 0 : 5;
      fill_phase(PHASE_ITEMS, step_max);
    end

    wait_settled();
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (err_cnt == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/hwsm_pkg.sv
rtl/hwsm_div.sv
rtl/hwsm_ctrl.sv
rtl/hwsm_dpath.sv
rtl/hall_wheel_speed_meter_core.sv
tb/tb_hall_wheel_speed_meter_core.sv
